FILE: design/sensor_to_dac_span_scaler_unit_defines.svh
// Assertion macros for the span scaler RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef SENSOR_TO_DAC_SPAN_SCALER_UNIT_DEFINES_SVH
`define SENSOR_TO_DAC_SPAN_SCALER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check held off while reset is asserted.
`define SDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("span scaler check failed");
// Check that must hold on every edge, reset included.
`define SDS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("span scaler check failed");
`else
`define SDS_ASSERT(lbl, clk, rstn, prop)
`define SDS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: design/sds_pkg.sv
// Shared types and constants for the span scaler.
// Used by the controller, the datapath and the top level.
package sds_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SPAN = 3'd4;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // take the beat, clamp the sample
    logic mul;    // form |product| and its sign
    logic step;   // one restoring divide step
    logic fin;    // correct, saturate, load output, capture span
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic span_zero;
  } dp_sts_t;

endpackage

FILE: design/sds_ctrl.sv
// Sequencer for the span scaler: accept, multiply, divide steps, finish.
// Depends on sds_pkg and the assertion macro header.
`include "sensor_to_dac_span_scaler_unit_defines.svh"

module sds_ctrl #(
  parameter int unsigned DIV_STEPS = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  sds_pkg::dp_sts_t  sts_i,
  output sds_pkg::dp_cmd_t  cmd_o
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  sds_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != sds_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      sds_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sds_pkg::ST_MUL;
        end
      end
      sds_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        // zero span skips the divider entirely
        state_d   = sts_i.span_zero ? sds_pkg::ST_FIN : sds_pkg::ST_DIV;
      end
      sds_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = sds_pkg::ST_FIN;
        end
      end
      sds_pkg::ST_FIN: begin
        if (out_free) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = sds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sds_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a pending result is never overwritten by the finish step
  `SDS_ASSERT(a_fin_waits, clk_i, rst_ni, (state_q == sds_pkg::ST_FIN && out_valid_q && out_stall_i) |=> (state_q == sds_pkg::ST_FIN))
  // finishing leaves a result on the output and returns to accept
  `SDS_ASSERT(a_fin_result, clk_i, rst_ni, cmd_o.fin |=> (out_valid_q && state_q == sds_pkg::ST_IDLE))
  // step counter never runs past the divide length
  `SDS_ASSERT(a_cnt_range, clk_i, rst_ni, (state_q != sds_pkg::ST_DIV) || (cnt_q <= CNT_W'(DIV_STEPS - 1)))

endmodule

FILE: design/sds_datapath.sv
// Datapath of the span scaler: clamp, multiply, restoring divider, saturation.
// Depends on sds_pkg; driven by sds_ctrl commands.
module sds_datapath #(
  parameter int unsigned DAC_BITS    = 12,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sds_pkg::dp_cmd_t       cmd_i,
  output sds_pkg::dp_sts_t       sts_o,
  input  logic                   cmd_bit_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] open_level_i,
  input  logic [SAMPLE_BITS-1:0] min_level_i,
  input  logic [DAC_BITS-1:0]    dac_low_i,
  input  logic [DAC_BITS-1:0]    dac_high_i,
  output logic [DAC_BITS-1:0]    dac_code_o,
  output logic                   clipped_o
);

  localparam int unsigned P_W   = SAMPLE_BITS + DAC_BITS;
  localparam int unsigned R_W   = SAMPLE_BITS + 1;
  localparam int unsigned SUM_W = P_W + 2;

  logic [SAMPLE_BITS-1:0] s_q, s_d, raw_q, span_q;
  logic                   capt_q, neg_q;
  logic [P_W-1:0]         acc_q, acc_d;
  logic [SAMPLE_BITS-1:0] rem_q;
  logic [R_W-1:0]         rem_d, rem_sh;
  logic                   ge;
  logic [DAC_BITS-1:0]    mag;
  logic                   neg;
  logic signed [SUM_W-1:0] lo_ext, q_ext, inc_ext, sum;
  logic [DAC_BITS-1:0]    code_q, code_d;
  logic                   clip_q, clip_d;
  logic [SAMPLE_BITS-1:0] s_open;

  assign sts_o.span_zero = (span_q == '0);
  assign dac_code_o      = code_q;
  assign clipped_o       = clip_q;

  // open sensor first, then floor at min_level
  always_comb begin
    s_open = (sample_i >= open_level_i) ? min_level_i : sample_i;
    s_d    = (s_open <= min_level_i) ? min_level_i : s_open;
  end

  // |dac_high - dac_low| and its sign
  assign neg = (dac_low_i > dac_high_i);
  assign mag = neg ? (dac_low_i - dac_high_i) : (dac_high_i - dac_low_i);

  // restoring divide step, quotient bits shift in behind the dividend
  always_comb begin
    rem_sh = {rem_q, acc_q[P_W-1]};
    ge     = (rem_sh >= {1'b0, span_q});
    rem_d  = ge ? (rem_sh - {1'b0, span_q}) : rem_sh;
    acc_d  = {acc_q[P_W-2:0], ge};
  end

  // floor correction for a negative numerator, then saturate
  always_comb begin
    lo_ext  = {{(SUM_W-DAC_BITS){1'b0}}, dac_low_i};
    q_ext   = {2'b00, acc_q};
    inc_ext = {{(SUM_W-1){1'b0}}, (rem_q != '0)};
    sum     = neg_q ? (lo_ext - q_ext - inc_ext) : (lo_ext + q_ext);
    if (sts_o.span_zero) begin
      code_d = dac_high_i;
      clip_d = 1'b1;
    end else if (sum[SUM_W-1]) begin
      code_d = '0;
      clip_d = 1'b1;
    end else if (sum[SUM_W-2:DAC_BITS] != '0) begin
      code_d = '1;
      clip_d = 1'b1;
    end else begin
      code_d = sum[DAC_BITS-1:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q    <= s_d;
      raw_q  <= sample_i;
      capt_q <= cmd_bit_i;
    end
    if (cmd_i.mul) begin
      neg_q <= neg;
      acc_q <= {{DAC_BITS{1'b0}}, s_q} * {{SAMPLE_BITS{1'b0}}, mag};
      rem_q <= '0;
    end else if (cmd_i.step) begin
      acc_q <= acc_d;
      rem_q <= rem_d[SAMPLE_BITS-1:0];
    end
    if (cmd_i.fin) begin
      code_q <= code_d;
      clip_q <= clip_d;
    end
  end

  // span is state: reset to full scale, captured from the raw sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '1;
    end else if (cmd_i.fin && capt_q) begin
      span_q <= raw_q;
    end
  end

endmodule

FILE: design/sensor_to_dac_span_scaler_unit.sv
// Top level of the sensor-to-DAC span scaler: config registers, sequencer, datapath.
// Depends on sds_pkg, sds_ctrl and sds_datapath.
//
// Each input beat carries a converter sample and a command bit and yields one
// output beat with a DAC code and a clip flag. The sample is clamped (open
// sensor and underrange both go to min_level), scaled as
// floor(s * (dac_high - dac_low) / span) + dac_low and saturated to the DAC
// range; a zero span gives dac_high with clip set. A command bit of one makes
// the raw sample the new span once the current beat is done. The block works
// on one beat at a time: it takes no new beat until the current one has gone
// through the multiply, the one-bit-per-cycle restoring divider and the finish
// step; with a zero span the divider is skipped. The result sits in an output
// register, so a new beat is taken while the previous result is still waiting.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// write it only while the block is idle, as the block itself does not enforce it.
// A write to initial_span is accepted but has no effect: the span starts at
// all ones after reset and changes only by capture.
module sensor_to_dac_span_scaler_unit #(
  parameter int unsigned DAC_BITS    = 12,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [DAC_BITS-1:0]             dac_code_o,
  output logic                            clipped_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [sds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [((SAMPLE_BITS > DAC_BITS) ? SAMPLE_BITS : DAC_BITS)-1:0] cfg_data_i
);

  // Config registers; upper data bits beyond each register are dropped.
  logic [SAMPLE_BITS-1:0] open_level_q, min_level_q;
  logic [DAC_BITS-1:0]    dac_low_q, dac_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_level_q <= '1;
      min_level_q  <= '0;
      dac_low_q    <= '0;
      dac_high_q   <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sds_pkg::CFG_OPEN_LEVEL: open_level_q <= cfg_data_i[SAMPLE_BITS-1:0];
        sds_pkg::CFG_MIN_LEVEL:  min_level_q  <= cfg_data_i[SAMPLE_BITS-1:0];
        sds_pkg::CFG_DAC_LOW:    dac_low_q    <= cfg_data_i[DAC_BITS-1:0];
        sds_pkg::CFG_DAC_HIGH:   dac_high_q   <= cfg_data_i[DAC_BITS-1:0];
        // only its reset value matters, and that is built into the span register
        sds_pkg::CFG_INITIAL_SPAN: ;
        default: ;
      endcase
    end
  end

  sds_pkg::dp_cmd_t cmd;
  sds_pkg::dp_sts_t sts;

  sds_ctrl #(
    .DIV_STEPS (SAMPLE_BITS + DAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sds_datapath #(
    .DAC_BITS    (DAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cmd_bit_i    (cmd_i),
    .sample_i     (sample_i),
    .open_level_i (open_level_q),
    .min_level_i  (min_level_q),
    .dac_low_i    (dac_low_q),
    .dac_high_i   (dac_high_q),
    .dac_code_o   (dac_code_o),
    .clipped_o    (clipped_o)
  );

endmodule

FILE: test/testbench.sv
// Self-checking bench for sensor_to_dac_span_scaler_unit: clamp, scale, saturate, span capture.
// Depends on sds_pkg and the unit RTL; runs stand-alone, no files or arguments.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DAC_W    = 12;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned IDX_W    = sds_pkg::CFG_IDX_W;
  localparam int unsigned CFG_W    = (SMP_W > DAC_W) ? SMP_W : DAC_W;
  // length of one beat from acceptance to the next, through the divider
  localparam int unsigned BEAT_CYC = SMP_W + DAC_W + 3;
  localparam int unsigned SETTLE   = 2 * BEAT_CYC;
  localparam int unsigned WDOG_MAX = 4000;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned PHASE_N  = 216;

  typedef struct packed {
    logic             cmd;
    logic [SMP_W-1:0] sample;
  } conv_beat_t;

  typedef struct packed {
    logic [DAC_W-1:0] dac_code;
    logic             clipped;
  } dac_beat_t;

  // ---------------------------------------------------------------------------
  // DUT-facing signals; the ones the bench drives are known from time zero
  // ---------------------------------------------------------------------------
  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd      = 1'b0;
  logic [SMP_W-1:0]     sample   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DAC_W-1:0]     dac_code;
  logic                 clipped;
  logic                 cfg_we   = 1'b0;
  logic [IDX_W-1:0]     cfg_idx  = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  sensor_to_dac_span_scaler_unit #(
    .DAC_BITS    (DAC_W),
    .SAMPLE_BITS (SMP_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (cmd),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .dac_code_o  (dac_code),
    .clipped_o   (clipped),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: config registers and the captured span
  // ---------------------------------------------------------------------------
  logic [SMP_W-1:0] open_lvl  = '1;
  logic [SMP_W-1:0] min_lvl   = '0;
  logic [DAC_W-1:0] dac_lo    = '0;
  logic [DAC_W-1:0] dac_hi    = '1;
  logic [SMP_W-1:0] init_span = '1;
  logic [SMP_W-1:0] span_cur  = '1;  // span after reset; only a capture moves it

  conv_beat_t beats_to_send[$];
  dac_beat_t  dac_expected[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;     // bumped by the sequencer to ask for a long hold-off
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned wdog = 0;
  int unsigned fail_count = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned captures = 0;
  int unsigned clip_hits = 0;
  int unsigned settings = 0;

  // Predicts the DAC beat for one converter beat and applies a capture to the span.
  function automatic dac_beat_t predict_dac_code(input logic cap, input logic [SMP_W-1:0] raw);
    logic [SMP_W-1:0] s;
    longint           diff;
    longint           num;
    longint           den;
    longint           q;
    longint           sum;
    dac_beat_t        r;
    s = raw;
    // open sensor first, then the underrange floor; both land on min_level
    if (s >= open_lvl) s = min_lvl;
    if (s <= min_lvl) s = min_lvl;
    r.clipped = 1'b0;
    if (span_cur == '0) begin
      r.dac_code = dac_hi;
      r.clipped  = 1'b1;
    end else begin
      diff = longint'(dac_hi) - longint'(dac_lo);
      num  = longint'(s) * diff;
      den  = longint'(span_cur);
      q    = num / den;
      // division truncates toward zero; floor wants one less for negative remainders
      if (num < 0 && (num % den) != 0) q = q - 1;
      sum = q + longint'(dac_lo);
      if (sum < 0) begin
        r.dac_code = '0;
        r.clipped  = 1'b1;
      end else if (sum > longint'({DAC_W{1'b1}})) begin
        r.dac_code = '1;
        r.clipped  = 1'b1;
      end else begin
        r.dac_code = sum[DAC_W-1:0];
      end
    end
    // capture takes the raw sample, effective from the next beat
    if (cap) span_cur = raw;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat at a time out of beats_to_send, random sender gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        dac_expected.push_back(predict_dac_code(cmd, sample));
        beats_in = beats_in + 1;
        if (cmd) captures = captures + 1;
      end
      // payload may only move when nothing is held or the held beat just went in
      if (!in_valid || !in_stall) begin
        if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          cmd      <= beats_to_send[0].cmd;
          sample   <= beats_to_send[0].sample;
          void'(beats_to_send.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each output beat against the oldest prediction, drive stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dac_beat_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        beats_out = beats_out + 1;
        if (clipped === 1'b1) clip_hits = clip_hits + 1;
        if (dac_expected.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("[%0t] unexpected beat: code %0d clip %0d", $realtime, dac_code, clipped);
        end else begin
          want = dac_expected.pop_front();
          if (dac_code !== want.dac_code || clipped !== want.clipped) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("[%0t] beat %0d: expected code %0d clip %0d, got code %0d clip %0d",
                       $realtime, beats_out, want.dac_code, want.clipped, dac_code, clipped);
          end
        end
      end
      // long hold-off runs in this process so the input side backs up
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_LEN;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("watchdog: no beat moved for %0d cycles", WDOG_MAX);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      sds_pkg::CFG_OPEN_LEVEL:   open_lvl  = val[SMP_W-1:0];
      sds_pkg::CFG_MIN_LEVEL:    min_lvl   = val[SMP_W-1:0];
      sds_pkg::CFG_DAC_LOW:      dac_lo    = val[DAC_W-1:0];
      sds_pkg::CFG_DAC_HIGH:     dac_hi    = val[DAC_W-1:0];
      sds_pkg::CFG_INITIAL_SPAN: init_span = val[SMP_W-1:0];  // span itself stays put
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Full register set, plus a write to every unused index (must be ignored).
  task automatic load_setting(input logic [CFG_W-1:0] ol, input logic [CFG_W-1:0] ml,
                              input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    int unsigned k;
    write_reg(sds_pkg::CFG_OPEN_LEVEL, ol);
    write_reg(sds_pkg::CFG_MIN_LEVEL, ml);
    write_reg(sds_pkg::CFG_DAC_LOW, lo);
    write_reg(sds_pkg::CFG_DAC_HIGH, hi);
    write_reg(sds_pkg::CFG_INITIAL_SPAN, CFG_W'($urandom));
    for (k = int'(sds_pkg::CFG_INITIAL_SPAN) + 1; k < (1 << IDX_W); k++)
      write_reg(IDX_W'(k), CFG_W'($urandom));
    settings = settings + 1;
  endtask

  task automatic push_beat(input logic c, input logic [SMP_W-1:0] s);
    conv_beat_t b;
    b.cmd    = c;
    b.sample = s;
    beats_to_send.push_back(b);
  endtask

  // Wait until every beat is in and every result is out, then let the block settle.
  task automatic drain();
    while (beats_to_send.size() > 0 || in_valid || dac_expected.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [SMP_W-1:0] near_level(input logic [SMP_W-1:0] lvl);
    int v;
    v = int'(lvl) + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > int'({SMP_W{1'b1}})) v = int'({SMP_W{1'b1}});
    return SMP_W'(v);
  endfunction

  // Random beat, weighted toward the clamp thresholds and the current span.
  task automatic push_random_beat();
    logic             c;
    logic [SMP_W-1:0] s;
    c = ($urandom_range(99) < 8);
    if (c) begin
      case ($urandom_range(9))
        0:       s = '0;                                // zero span next
        1:       s = SMP_W'($urandom_range(64, 1));
        2, 3:    s = SMP_W'($urandom);
        default: s = SMP_W'($urandom_range({SMP_W{1'b1}}, 1000));
      endcase
    end else begin
      case ($urandom_range(9))
        4, 5:    s = SMP_W'($urandom_range(span_cur, 0));
        6:       s = near_level(open_lvl);
        7:       s = near_level(min_lvl);
        8:       s = $urandom_range(1) ? '1 : '0;
        9:       s = SMP_W'($urandom_range(15));
        default: s = SMP_W'($urandom);
      endcase
    end
    push_beat(c, s);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    int unsigned i;
    logic [CFG_W-1:0] lo;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed, reset settings: field extremes, bit patterns, open sensor, zero span,
    // capture, sample above span
    push_beat(1'b0, 16'h0000);
    push_beat(1'b0, 16'hFFFF);   // open sensor with open_level at all ones
    push_beat(1'b0, 16'hFFFE);
    push_beat(1'b0, 16'h0001);
    push_beat(1'b0, 16'h8000);
    push_beat(1'b0, 16'hAAAA);
    push_beat(1'b0, 16'h5555);
    push_beat(1'b1, 16'h0000);   // capture zero span
    push_beat(1'b0, 16'h1234);   // zero span: dac_high, clipped
    push_beat(1'b1, 16'd1000);   // still the zero span for this beat
    push_beat(1'b0, 16'd999);
    push_beat(1'b0, 16'd1000);
    push_beat(1'b0, 16'd2000);   // above span, saturates high
    push_beat(1'b1, 16'hFFFF);
    push_beat(1'b0, 16'd40000);
    drain();

    // Directed: min at or above open, masked DAC limits, reversed limits, result below zero
    load_setting(16'd100, 16'd200, 16'hF0FF, 16'h0010);
    push_beat(1'b0, 16'd50);
    push_beat(1'b0, 16'd150);
    push_beat(1'b0, 16'd250);
    push_beat(1'b1, 16'd100);    // small span
    push_beat(1'b0, 16'd0);      // clamped to 200 > span, reversed slope: below zero
    push_beat(1'b0, 16'hFFFF);
    push_beat(1'b1, 16'hFFFF);
    push_beat(1'b0, 16'd7);
    drain();

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: load_setting(16'hFFFF, 16'h0000, 16'h0000, 16'h0FFF);
        1: load_setting(16'h0000, 16'hFFFF, 16'h0FFF, 16'h0000);
        4: begin
          lo = CFG_W'($urandom);
          load_setting(CFG_W'($urandom_range(65535, 50000)), CFG_W'($urandom_range(8000)),
                       lo, lo);  // equal limits, zero slope
        end
        7: load_setting(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                        CFG_W'($urandom));
        default: load_setting(CFG_W'($urandom_range(65535, 50000)),
                              CFG_W'($urandom_range(8000)),
                              CFG_W'($urandom), CFG_W'($urandom));
      endcase
      // idle modes: none, sender 55, receiver 55, both 20
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (i = 0; i < PHASE_N; i++) push_random_beat();
      // receiver holds off while the sender keeps offering: block fills and stalls input
      if (ph == 4) hold_req = hold_req + 1;
      if (ph == 5) begin
        // sender pauses mid-phase until every result is back
        drain();
        for (i = 0; i < PHASE_N / 4; i++) push_random_beat();
      end
      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end

    drain();
    if (dac_expected.size() != 0) fail_count = fail_count + dac_expected.size();

    $display("run: %0d beats in, %0d DAC beats checked, %0d span captures, %0d clipped",
             beats_in, beats_out, captures, clip_hits);
    $display("     over %0d register settings and four sender/receiver idle modes", settings);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sensor_to_dac_span_scaler_unit.f
+incdir+design
design/sds_pkg.sv
design/sds_ctrl.sv
design/sds_datapath.sv
design/sensor_to_dac_span_scaler_unit.sv
test/testbench.sv
